// File: rtl/yfu_pkg.sv
// yfu_pkg: shared widths, codes and item types of the yee field update stream unit
// no dependencies; imported by yfu_front, yfu_back and the top level
package yfu_pkg;

    // fixed-point formats
    localparam int VALUE_BITS = 32;
    localparam int COEF_BITS  = 32;
    localparam int FRAC_BITS  = 28;
    localparam int DIFF_BITS  = VALUE_BITS + 1;
    localparam int PROD_BITS  = COEF_BITS + DIFF_BITS;
    localparam int SUM_BITS   = PROD_BITS + 3;

    // configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 9;
    localparam int COMP_BITS     = 3;
    localparam int SIZE_X_BITS   = 9;
    localparam int SIZE_Y_BITS   = 7;
    localparam int SIZE_Z_BITS   = 7;

    // x extent is fixed by the size_x register
    localparam int LIMIT_X    = 256;
    localparam int POS_X_BITS = 8;

    // decoupling queues
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 4;
    localparam int MID_CW    = $clog2(MID_DEPTH + 1);
    localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_COMPONENT = 2'd0,
        CFG_SIZE_X    = 2'd1,
        CFG_SIZE_Y    = 2'd2,
        CFG_SIZE_Z    = 2'd3
    } t_cfg_idx;

    // component codes: hx hy hz ex ey ez, codes above ez are unused
    localparam logic [COMP_BITS-1:0] COMP_HX = 3'd0;
    localparam logic [COMP_BITS-1:0] COMP_HY = 3'd1;
    localparam logic [COMP_BITS-1:0] COMP_HZ = 3'd2;
    localparam logic [COMP_BITS-1:0] COMP_EX = 3'd3;
    localparam logic [COMP_BITS-1:0] COMP_EY = 3'd4;
    localparam logic [COMP_BITS-1:0] COMP_EZ = 3'd5;

    // difference axes (a, b) of a component
    typedef enum logic [1:0] {
        PAIR_YZ = 2'd0,
        PAIR_ZX = 2'd1,
        PAIR_XY = 2'd2
    } t_pair;

    // unit decay for magnetic components
    localparam logic [COEF_BITS-1:0] K_ONE = COEF_BITS'(64'd1 << FRAC_BITS);

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] own_value;
        logic signed [COEF_BITS-1:0]  decay_coef;
        logic signed [COEF_BITS-1:0]  coef_a;
        logic signed [COEF_BITS-1:0]  coef_b;
        logic signed [VALUE_BITS-1:0] field_a;
        logic signed [VALUE_BITS-1:0] field_b;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] new_value;
        logic                         was_updated;
        logic                         last_cell;
    } t_out_item;

    // classified request handed from front to back
    typedef struct packed {
        logic signed [VALUE_BITS-1:0] own;
        logic signed [COEF_BITS-1:0]  k;
        logic signed [COEF_BITS-1:0]  ca;
        logic signed [COEF_BITS-1:0]  cb;
        logic signed [DIFF_BITS-1:0]  da;
        logic signed [DIFF_BITS-1:0]  db;
        logic                         update;
        logic                         last;
    } t_work;

endpackage

// File: rtl/yfu_ram.sv
// yfu_ram: generic single-write, single-read ram with registered read data
// read-first on a same-address write; no dependencies
module yfu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/yfu_fifo.sv
// yfu_fifo: small register queue with head on the output and a fill count
// no dependencies
module yfu_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [WIDTH-1:0]               i_data,
    input  logic                           i_pop,
    output logic [WIDTH-1:0]               o_data,
    output logic                           o_empty,
    output logic [$clog2(DEPTH+1)-1:0]     o_used
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_used, n_used;
    logic             do_push, do_pop;

    assign do_push = i_push && (r_used != CW'(DEPTH));
    assign do_pop  = i_pop && (r_used != '0);

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_used = r_used;
        if (do_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_used = r_used + CW'(1);
        end else if (do_pop && !do_push) begin
            n_used = r_used - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_used <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_used <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_empty = (r_used == '0);
    assign o_used  = r_used;

endmodule

// File: rtl/yfu_front.sv
// yfu_front: configuration, stream counters, neighbor stores and classification
// depends on yfu_pkg and yfu_ram
module yfu_front
    import yfu_pkg::*;
#(
    parameter int MAX_Y = 64,
    parameter int MAX_Z = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  t_in_item                  i_item,
    output logic                      o_full,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic [MID_CW-1:0]         i_q_used,
    output logic                      o_work_valid,
    output t_work                     o_work
);

    localparam int PYW = $clog2(MAX_Y);
    localparam int PZW = $clog2(MAX_Z);
    localparam int YSW = $clog2(MAX_Y + 1);
    localparam int ZSW = $clog2(MAX_Z + 1);
    localparam int XSW = $clog2(LIMIT_X + 1);
    localparam int PAW = $clog2(MAX_Y * MAX_Z);

    // configuration registers
    logic [COMP_BITS-1:0]   r_component;
    logic [SIZE_X_BITS-1:0] r_size_x;
    logic [SIZE_Y_BITS-1:0] r_size_y;
    logic [SIZE_Z_BITS-1:0] r_size_z;

    // stream position
    logic [POS_X_BITS-1:0]  r_pos_x, n_pos_x;
    logic [PYW-1:0]         r_pos_y, n_pos_y;
    logic [PZW-1:0]         r_pos_z, n_pos_z;

    logic [XSW-1:0] sx_eff;
    logic [YSW-1:0] sy_eff;
    logic [ZSW-1:0] sz_eff;
    logic           x_end, y_end, z_end;

    logic           accept;
    logic           comp_ok;
    t_pair          pair;
    logic           first_a, first_b;
    logic           we_plane, we_row, we_z;
    logic [VALUE_BITS-1:0] wd_plane, wd_row, wd_z;
    logic [PAW-1:0] plane_addr;
    logic [VALUE_BITS-1:0] plane_rd, row_rd;
    logic [VALUE_BITS-1:0] r_prev_z;

    // registered stage waiting for store read data
    logic                         r_f1_valid;
    t_in_item                     r_f1_item;
    logic [VALUE_BITS-1:0]        r_f1_zprev;
    t_pair                        r_f1_pair;
    logic                         r_f1_update;
    logic                         r_f1_last;
    logic                         r_f1_magnetic;
    logic signed [VALUE_BITS-1:0] pa, pb;

    // the stage register always drains into the queue, so reserve its slot
    assign o_full = (i_q_used + MID_CW'(r_f1_valid)) >= MID_CW'(MID_DEPTH);
    assign accept = i_push && !o_full;

    // effective box size: zero acts as one, clamp y and z to the store limits and x to LIMIT_X
    always_comb begin
        if (r_size_x == '0) begin
            sx_eff = XSW'(1);
        end else if (32'(r_size_x) > LIMIT_X) begin
            sx_eff = XSW'(LIMIT_X);
        end else begin
            sx_eff = XSW'(r_size_x);
        end
        if (r_size_y == '0) begin
            sy_eff = YSW'(1);
        end else if (32'(r_size_y) > MAX_Y) begin
            sy_eff = YSW'(MAX_Y);
        end else begin
            sy_eff = YSW'(r_size_y);
        end
        if (r_size_z == '0) begin
            sz_eff = ZSW'(1);
        end else if (32'(r_size_z) > MAX_Z) begin
            sz_eff = ZSW'(MAX_Z);
        end else begin
            sz_eff = ZSW'(r_size_z);
        end
    end

    assign x_end = (XSW'(r_pos_x) + XSW'(1)) >= sx_eff;
    assign y_end = (YSW'(r_pos_y) + YSW'(1)) >= sy_eff;
    assign z_end = (ZSW'(r_pos_z) + ZSW'(1)) >= sz_eff;

    always_comb begin
        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        n_pos_z = r_pos_z;
        if (z_end) begin
            n_pos_z = '0;
            if (y_end) begin
                n_pos_y = '0;
                n_pos_x = x_end ? '0 : r_pos_x + POS_X_BITS'(1);
            end else begin
                n_pos_y = r_pos_y + PYW'(1);
            end
        end else begin
            n_pos_z = r_pos_z + PZW'(1);
        end
    end

    // axis pair from the component
    always_comb begin
        case (r_component)
            COMP_HX, COMP_EX: pair = PAIR_YZ;
            COMP_HY, COMP_EY: pair = PAIR_ZX;
            default:          pair = PAIR_XY;
        endcase
    end

    assign comp_ok = (r_component <= COMP_EZ);

    always_comb begin
        first_a  = 1'b0;
        first_b  = 1'b0;
        we_plane = 1'b0;
        we_row   = 1'b0;
        we_z     = 1'b0;
        wd_plane = i_item.field_a;
        wd_row   = i_item.field_a;
        wd_z     = i_item.field_a;
        case (pair)
            PAIR_YZ: begin
                first_a = (r_pos_y == '0);
                first_b = (r_pos_z == '0);
                we_row  = 1'b1;
                wd_row  = i_item.field_a;
                we_z    = 1'b1;
                wd_z    = i_item.field_b;
            end
            PAIR_ZX: begin
                first_a  = (r_pos_z == '0);
                first_b  = (r_pos_x == '0);
                we_z     = 1'b1;
                wd_z     = i_item.field_a;
                we_plane = 1'b1;
                wd_plane = i_item.field_b;
            end
            PAIR_XY: begin
                first_a  = (r_pos_x == '0);
                first_b  = (r_pos_y == '0);
                we_plane = 1'b1;
                wd_plane = i_item.field_a;
                we_row   = 1'b1;
                wd_row   = i_item.field_b;
            end
            default: begin
                first_a = 1'b1;
            end
        endcase
    end

    assign plane_addr = PAW'(32'(r_pos_y) * MAX_Z + 32'(r_pos_z));

    yfu_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_Y * MAX_Z)
    ) u_plane (
        .i_clk   (i_clk),
        .i_we    (accept && comp_ok && we_plane),
        .i_waddr (plane_addr),
        .i_wdata (wd_plane),
        .i_re    (accept),
        .i_raddr (plane_addr),
        .o_rdata (plane_rd)
    );

    yfu_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_Z)
    ) u_row (
        .i_clk   (i_clk),
        .i_we    (accept && comp_ok && we_row),
        .i_waddr (r_pos_z),
        .i_wdata (wd_row),
        .i_re    (accept),
        .i_raddr (r_pos_z),
        .o_rdata (row_rd)
    );

    // config and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_component <= COMP_HX;
            r_size_x    <= SIZE_X_BITS'(1);
            r_size_y    <= SIZE_Y_BITS'(1);
            r_size_z    <= SIZE_Z_BITS'(1);
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_pos_z     <= '0;
            r_f1_valid  <= 1'b0;
        end else begin
            r_f1_valid <= accept;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_COMPONENT: r_component <= i_cfg_data[COMP_BITS-1:0];
                    CFG_SIZE_X:    r_size_x    <= i_cfg_data[SIZE_X_BITS-1:0];
                    CFG_SIZE_Y:    r_size_y    <= i_cfg_data[SIZE_Y_BITS-1:0];
                    CFG_SIZE_Z:    r_size_z    <= i_cfg_data[SIZE_Z_BITS-1:0];
                    default:       r_component <= r_component;
                endcase
                r_pos_x <= '0;
                r_pos_y <= '0;
                r_pos_z <= '0;
            end else if (accept) begin
                r_pos_x <= n_pos_x;
                r_pos_y <= n_pos_y;
                r_pos_z <= n_pos_z;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (comp_ok && we_z) begin
                r_prev_z <= wd_z;
            end
            r_f1_item     <= i_item;
            r_f1_zprev    <= r_prev_z;
            r_f1_pair     <= pair;
            r_f1_update   <= comp_ok && !first_a && !first_b;
            r_f1_last     <= x_end && y_end && z_end;
            r_f1_magnetic <= (r_component <= COMP_HZ);
        end
    end

    // previous neighbors from the stores
    always_comb begin
        case (r_f1_pair)
            PAIR_YZ: begin
                pa = row_rd;
                pb = r_f1_zprev;
            end
            PAIR_ZX: begin
                pa = r_f1_zprev;
                pb = plane_rd;
            end
            default: begin
                pa = plane_rd;
                pb = row_rd;
            end
        endcase
    end

    always_comb begin
        o_work.own    = r_f1_item.own_value;
        o_work.k      = r_f1_magnetic ? K_ONE : r_f1_item.decay_coef;
        o_work.ca     = r_f1_item.coef_a;
        o_work.cb     = r_f1_item.coef_b;
        o_work.da     = {r_f1_item.field_a[VALUE_BITS-1], r_f1_item.field_a}
                        - {pa[VALUE_BITS-1], pa};
        o_work.db     = {pb[VALUE_BITS-1], pb}
                        - {r_f1_item.field_b[VALUE_BITS-1], r_f1_item.field_b};
        o_work.update = r_f1_update;
        o_work.last   = r_f1_last;
    end

    assign o_work_valid = r_f1_valid;

endmodule

// File: rtl/yfu_back.sv
// yfu_back: multiply, sum, round and saturate stages of the field update
// depends on yfu_pkg
module yfu_back
    import yfu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_work              i_work,
    output logic               o_pop,
    input  logic [OUT_CW-1:0]  i_out_used,
    output logic               o_res_valid,
    output t_out_item          o_res
);

    localparam logic signed [SUM_BITS-1:0] ROUND_HALF =
        SUM_BITS'(1) << (FRAC_BITS - 1);

    logic                           r_v1;
    logic signed [2*COEF_BITS-1:0]  r_p0;
    logic signed [PROD_BITS-1:0]    r_p1;
    logic signed [PROD_BITS-1:0]    r_p2;
    logic signed [VALUE_BITS-1:0]   r_own1;
    logic                           r_upd1;
    logic                           r_last1;

    logic                           r_v2;
    logic signed [SUM_BITS-1:0]     r_sum;
    logic signed [VALUE_BITS-1:0]   r_own2;
    logic                           r_upd2;
    logic                           r_last2;

    logic signed [SUM_BITS-1:0]     shifted;
    logic                           ovf;
    logic signed [VALUE_BITS-1:0]   sat;

    // issue only while every request in flight has a slot in the result queue
    assign o_pop = i_valid &&
                   ((i_out_used + OUT_CW'(r_v1) + OUT_CW'(r_v2)) < OUT_CW'(OUT_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= o_pop;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_p0    <= i_work.k * i_work.own;
            r_p1    <= i_work.ca * i_work.da;
            r_p2    <= i_work.cb * i_work.db;
            r_own1  <= i_work.own;
            r_upd1  <= i_work.update;
            r_last1 <= i_work.last;
        end
        if (r_v1) begin
            r_sum   <= SUM_BITS'(r_p0) + SUM_BITS'(r_p1) + SUM_BITS'(r_p2) + ROUND_HALF;
            r_own2  <= r_own1;
            r_upd2  <= r_upd1;
            r_last2 <= r_last1;
        end
    end

    // saturate when the bits above the result width are not a sign extension
    assign shifted = r_sum >>> FRAC_BITS;
    assign ovf = !((&shifted[SUM_BITS-1:VALUE_BITS-1]) ||
                   !(|shifted[SUM_BITS-1:VALUE_BITS-1]));

    always_comb begin
        if (ovf) begin
            sat = shifted[SUM_BITS-1] ? {1'b1, {(VALUE_BITS-1){1'b0}}}
                                      : {1'b0, {(VALUE_BITS-1){1'b1}}};
        end else begin
            sat = shifted[VALUE_BITS-1:0];
        end
    end

    assign o_res_valid       = r_v2;
    assign o_res.new_value   = r_upd2 ? sat : r_own2;
    assign o_res.was_updated = r_upd2;
    assign o_res.last_cell   = r_last2;

endmodule

// File: rtl/yee_field_update_stream_unit.sv
// yee_field_update_stream_unit: top level of the streaming yee grid field update
// depends on yfu_pkg, yfu_front, yfu_back, yfu_fifo (and yfu_ram via yfu_front)

// Updates one field component of a yee grid, one cell per request, cells
// streamed in raster order (x slowest, z fastest): electric components
// ascending, magnetic descending. Each request gives the new value
// decay*own + coef_a*dA - coef_b*dB, rounded and saturated, where dA and dB are
// the differences of field_a and field_b against the cell one stream step
// back along their axes. Cells at the first stream position along either axis
// pass own_value through with was_updated low. Sustained rate is one request
// per cycle in both directions while results are popped; a request passes
// the registered read of the plane and row stores, the queue between front
// and back, the three multipliers and the sum and rounding, in that order,
// before its result reaches the output queue. The neighbor stores need no
// clearing after reset, so a request may be pushed in the first cycle after
// reset. The user must write configuration only while no request is in flight;
// the block does not enforce it. Any write restarts the box at the first cell.
module yee_field_update_stream_unit
    import yfu_pkg::*;
#(
    parameter int MAX_Y = 64,
    parameter int MAX_Z = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // request side
    input  logic                      push,
    output logic                      full,
    input  t_in_item                  i_in_item,
    // result side
    output logic                      empty,
    input  logic                      pop,
    output t_out_item                 o_out_item,
    // configuration writes
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    // front to queue
    logic               work_valid;
    t_work              work_in;
    // queue to back
    t_work              work_head;
    logic               work_empty;
    logic [MID_CW-1:0]  work_used;
    logic               back_pop;
    // back to result queue
    logic               res_valid;
    t_out_item          res;
    logic [OUT_CW-1:0]  out_used;

    // front: counters, neighbor stores and boundary classification
    yfu_front #(
        .MAX_Y (MAX_Y),
        .MAX_Z (MAX_Z)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_item       (i_in_item),
        .o_full       (full),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_q_used     (work_used),
        .o_work_valid (work_valid),
        .o_work       (work_in)
    );

    // classified requests wait here so front and back stall independently
    yfu_fifo #(
        .WIDTH ($bits(t_work)),
        .DEPTH (MID_DEPTH)
    ) u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (work_valid),
        .i_data  (work_in),
        .i_pop   (back_pop),
        .o_data  (work_head),
        .o_empty (work_empty),
        .o_used  (work_used)
    );

    // back: products, sum, rounding and saturation
    yfu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (!work_empty),
        .i_work      (work_head),
        .o_pop       (back_pop),
        .i_out_used  (out_used),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // finished results wait here for the consumer
    yfu_fifo #(
        .WIDTH ($bits(t_out_item)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .i_pop   (pop),
        .o_data  (o_out_item),
        .o_empty (empty),
        .o_used  (out_used)
    );

endmodule

// File: tb/yfu_tb_pkg.sv
// yfu_tb_pkg: scoreboard class for the yee field update stream unit testbench
// depends on yfu_pkg for item types, widths and component codes
`timescale 1ns / 1ps
package yfu_tb_pkg;
    import yfu_pkg::*;

    // neighbor store extents, equal to the block's default parameters
    localparam int GRID_Y = 64;
    localparam int GRID_Z = 64;

    // unused component codes, passed through without store writes
    localparam logic [COMP_BITS-1:0] COMP_SPARE_6 = 3'd6;
    localparam logic [COMP_BITS-1:0] COMP_SPARE_7 = 3'd7;

    localparam logic signed [127:0] SAT_HI = (128'sd1 <<< (VALUE_BITS - 1)) - 128'sd1;
    localparam logic signed [127:0] SAT_LO = -(128'sd1 <<< (VALUE_BITS - 1));

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } t_axis;

    class cell_update_scoreboard;
        logic signed [VALUE_BITS-1:0] plane_vals [GRID_Y*GRID_Z];
        logic signed [VALUE_BITS-1:0] row_vals [GRID_Z];
        logic signed [VALUE_BITS-1:0] prev_z_val;
        int unsigned pos_x, pos_y, pos_z;
        logic [COMP_BITS-1:0]   comp;
        logic [SIZE_X_BITS-1:0] size_x;
        logic [SIZE_Y_BITS-1:0] size_y;
        logic [SIZE_Z_BITS-1:0] size_z;
        t_out_item expected_cells [$];
        int errors;
        int results_seen;
        int updates_seen;

        function new();
            foreach (plane_vals[i]) plane_vals[i] = '0;
            foreach (row_vals[i]) row_vals[i] = '0;
            prev_z_val = '0;
            pos_x = 0;
            pos_y = 0;
            pos_z = 0;
            comp = COMP_HX;
            size_x = SIZE_X_BITS'(1);
            size_y = SIZE_Y_BITS'(1);
            size_z = SIZE_Z_BITS'(1);
            errors = 0;
            results_seen = 0;
            updates_seen = 0;
        endfunction

        function void set_register(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_COMPONENT: comp = data[COMP_BITS-1:0];
                CFG_SIZE_X:    size_x = data[SIZE_X_BITS-1:0];
                CFG_SIZE_Y:    size_y = data[SIZE_Y_BITS-1:0];
                default:       size_z = data[SIZE_Z_BITS-1:0];
            endcase
            pos_x = 0;
            pos_y = 0;
            pos_z = 0;
        endfunction

        function int unsigned clamp_size(int unsigned v, int unsigned lim);
            if (v == 0) return 1;
            return (v > lim) ? lim : v;
        endfunction

        // read the neighbor one stream step back along an axis, then store this cell
        function void swap_axis(t_axis ax, logic signed [VALUE_BITS-1:0] cur,
                                output logic signed [VALUE_BITS-1:0] prev, output bit first);
            int unsigned idx;
            idx = pos_y * GRID_Z + pos_z;
            case (ax)
                AXIS_X: begin
                    first = (pos_x == 0);
                    prev = plane_vals[idx];
                    plane_vals[idx] = cur;
                end
                AXIS_Y: begin
                    first = (pos_y == 0);
                    prev = row_vals[pos_z];
                    row_vals[pos_z] = cur;
                end
                default: begin
                    first = (pos_z == 0);
                    prev = prev_z_val;
                    prev_z_val = cur;
                end
            endcase
        endfunction

        function int outstanding();
            return expected_cells.size();
        endfunction

        // predict the result of one accepted request and queue it
        function void note_request(t_in_item req);
            logic signed [VALUE_BITS-1:0] prev_a, prev_b;
            bit first_a, first_b;
            t_axis ax_a, ax_b;
            logic signed [127:0] acc, k_w, own_w, ca_w, cb_w, fa_w, fb_w, pa_w, pb_w;
            int unsigned sx, sy, sz;
            t_out_item res_item;

            sx = clamp_size(size_x, LIMIT_X);
            sy = clamp_size(size_y, GRID_Y);
            sz = clamp_size(size_z, GRID_Z);
            res_item.new_value = req.own_value;
            res_item.was_updated = 1'b0;

            if (comp <= COMP_EZ) begin
                case (t_pair'(2'(comp % 3)))
                    PAIR_YZ: begin ax_a = AXIS_Y; ax_b = AXIS_Z; end
                    PAIR_ZX: begin ax_a = AXIS_Z; ax_b = AXIS_X; end
                    default: begin ax_a = AXIS_X; ax_b = AXIS_Y; end
                endcase
                swap_axis(ax_a, req.field_a, prev_a, first_a);
                swap_axis(ax_b, req.field_b, prev_b, first_b);
                if (!first_a && !first_b) begin
                    // magnetic components ignore decay_coef
                    if (comp < COMP_EX) k_w = $signed(K_ONE);
                    else k_w = req.decay_coef;
                    own_w = req.own_value;
                    ca_w = req.coef_a;
                    cb_w = req.coef_b;
                    fa_w = req.field_a;
                    fb_w = req.field_b;
                    pa_w = prev_a;
                    pb_w = prev_b;
                    acc = k_w * own_w + ca_w * (fa_w - pa_w) + cb_w * (pb_w - fb_w);
                    // round half up, then saturate
                    acc = (acc + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
                    if (acc > SAT_HI) acc = SAT_HI;
                    else if (acc < SAT_LO) acc = SAT_LO;
                    res_item.new_value = acc[VALUE_BITS-1:0];
                    res_item.was_updated = 1'b1;
                end
            end

            res_item.last_cell = (pos_x + 1 >= sx) && (pos_y + 1 >= sy) && (pos_z + 1 >= sz);

            pos_z++;
            if (pos_z >= sz) begin
                pos_z = 0;
                pos_y++;
                if (pos_y >= sy) begin
                    pos_y = 0;
                    pos_x++;
                    if (pos_x >= sx) pos_x = 0;
                end
            end
            expected_cells.push_back(res_item);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_cells.size() == 0) begin
                $display("%0t: result with no pending request: new_value %0d", $time,
                         got.new_value);
                errors++;
                return;
            end
            want = expected_cells.pop_front();
            results_seen++;
            if (want.was_updated) updates_seen++;
            if (got.new_value !== want.new_value) begin
                $display("%0t: new_value mismatch: expected %0d, actual %0d", $time,
                         want.new_value, got.new_value);
                errors++;
            end
            if (got.was_updated !== want.was_updated) begin
                $display("%0t: was_updated mismatch: expected %0b, actual %0b", $time,
                         want.was_updated, got.was_updated);
                errors++;
            end
            if (got.last_cell !== want.last_cell) begin
                $display("%0t: last_cell mismatch: expected %0b, actual %0b", $time,
                         want.last_cell, got.last_cell);
                errors++;
            end
        endfunction
    endclass

endpackage

// File: tb/yee_field_update_stream_unit_tb.sv
// yee_field_update_stream_unit_tb: self-checking bench for the yee field update stream unit
// depends on yfu_pkg, yfu_tb_pkg and the rtl under rtl
`timescale 1ns / 1ps
module yee_field_update_stream_unit_tb;
    import yfu_pkg::*;
    import yfu_tb_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 11;
    // a result reaches the output queue through the store read, work queue, multiply and sum registers
    localparam int SETTLE_CYCLES = 6;
    // longest quiet stretch of a correct run is the receiver hold-off
    localparam int IDLE_LIMIT    = 4000;
    localparam int HOLD_AT       = 60;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 700;

    logic i_clk    = 1'b0;
    logic i_rst_n  = 1'b0;
    logic push     = 1'b0;
    logic pop      = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    t_in_item  i_in_item = '0;
    logic      full;
    logic      empty;
    t_out_item o_out_item;

    cell_update_scoreboard cell_check = new();

    int requests_in  = 0;
    int idle_cycles  = 0;
    int phases_run   = 0;
    int random_items = 0;
    bit hold_done    = 1'b0;

    yee_field_update_stream_unit #(
        .MAX_Y(GRID_Y),
        .MAX_Z(GRID_Z)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // monitor: everything read here is the value from before the edge
    always @(posedge i_clk) begin
        if (push && !full) begin
            cell_check.note_request(i_in_item);
            requests_in++;
        end
        if (pop && !empty) cell_check.check_result(o_out_item);
        // watchdog on handshake progress
        if ((push && !full) || (pop && !empty)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $time, idle_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // one field value: extremes, moderate magnitudes or fully random bits
    function automatic logic signed [31:0] pick_field_value(bit extreme_only, bit is_coef);
        int unsigned sel;
        sel = extreme_only ? 0 : $urandom_range(0, 3);
        case (sel)
            0: begin
                case ($urandom_range(0, 4))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7fff_ffff;
                    2:       return 32'sd0;
                    3:       return -32'sd1;
                    default: return is_coef ? $signed(K_ONE) : 32'sd1;
                endcase
            end
            // coefficients within +-1.0 keep most sums out of saturation
            1: begin
                if (is_coef) return int'($urandom_range(0, 1 << 29)) - (1 << 28);
                return int'($urandom_range(0, 1 << 21)) - (1 << 20);
            end
            default: return $urandom();
        endcase
    endfunction

    function automatic t_in_item make_request(bit extreme_only);
        t_in_item req;
        req.own_value  = pick_field_value(extreme_only, 1'b0);
        req.decay_coef = pick_field_value(extreme_only, 1'b1);
        req.coef_a     = pick_field_value(extreme_only, 1'b1);
        req.coef_b     = pick_field_value(extreme_only, 1'b1);
        req.field_a    = pick_field_value(extreme_only, 1'b0);
        req.field_b    = pick_field_value(extreme_only, 1'b0);
        return req;
    endfunction

    task automatic write_register(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        cell_check.set_register(idx, data);
    endtask

    // offer one request and return at the edge that takes it, push left high
    task automatic send_request(t_in_item req);
        push      <= 1'b1;
        i_in_item <= req;
        do @(posedge i_clk); while (full);
    endtask

    // one edge first so the monitor has noted the last request
    task automatic wait_until_drained();
        @(posedge i_clk);
        while (cell_check.outstanding() != 0) @(posedge i_clk);
    endtask

    // reconfigure while idle, then stream requests in bursts with random gaps
    task automatic run_phase(logic [COMP_BITS-1:0] comp, logic [8:0] sx, logic [8:0] sy,
                             logic [8:0] sz, int n_items, bit extreme_only);
        int burst;
        int gap;
        bit steady;
        push <= 1'b0;
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_register(CFG_COMPONENT, comp);
        write_register(CFG_SIZE_X, sx);
        write_register(CFG_SIZE_Y, sy);
        write_register(CFG_SIZE_Z, sz);
        i_cfg_we <= 1'b0;
        // some phases run back to back with no sender gaps at all
        steady = ($urandom_range(0, 3) == 0);
        burst = $urandom_range(1, 16);
        for (int n = 0; n < n_items; n++) begin
            send_request(make_request(extreme_only));
            burst--;
            if (burst == 0) begin
                burst = $urandom_range(1, 16);
                gap = steady ? 0 : $urandom_range(0, 6);
                if (gap > 0) begin
                    push <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
        phases_run++;
    endtask

    // receiver: pop pattern changes per segment, plus one long hold-off
    initial begin
        int seg;
        int mode;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            mode = $urandom_range(0, 3);
            seg = $urandom_range(8, 100);
            repeat (seg) begin
                @(posedge i_clk);
                // hold off long enough for the block to fill and raise full
                if (!hold_done && requests_in >= HOLD_AT) begin
                    hold_done = 1'b1;
                    pop <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end
                case (mode)
                    0:       pop <= 1'b1;
                    1:       pop <= ($urandom_range(0, 3) != 0);
                    2:       pop <= 1'($urandom_range(0, 1));
                    default: pop <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // stimulus sequence
    initial begin
        logic [COMP_BITS-1:0] comp;
        logic [8:0] sx, sy, sz;
        int box;
        int n_items;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every component on its smallest box that reaches an update,
        // with extreme field values so sums saturate both ways
        run_phase(COMP_HX, 9'd1, 9'd2, 9'd2, 4, 1'b1);
        run_phase(COMP_HY, 9'd2, 9'd1, 9'd2, 4, 1'b1);
        run_phase(COMP_HZ, 9'd2, 9'd2, 9'd1, 4, 1'b1);
        // box cut short, the next register write restarts at the first cell
        run_phase(COMP_EX, 9'd1, 9'd2, 9'd2, 2, 1'b1);
        run_phase(COMP_EX, 9'd1, 9'd2, 9'd2, 4, 1'b1);
        run_phase(COMP_EY, 9'd2, 9'd1, 9'd2, 4, 1'b1);
        run_phase(COMP_EZ, 9'd2, 9'd2, 9'd1, 4, 1'b1);
        // unused codes pass through, zero sizes act as one
        run_phase(COMP_SPARE_6, 9'd0, 9'd0, 9'd0, 1, 1'b1);
        run_phase(COMP_SPARE_7, 9'd0, 9'd0, 9'd0, 1, 1'b1);

        // oversized registers clamp to the limits; last_cell shows where the box ends
        // the receiver hold-off falls inside the first of these
        run_phase(COMP_EY, 9'd511, 9'd1, 9'd1, 256, 1'b0);
        run_phase(COMP_EX, 9'd1, 9'd127, 9'd2, 128, 1'b0);
        run_phase(COMP_HX, 9'd1, 9'd2, 9'd127, 128, 1'b0);
        random_items = 512;

        // random small boxes, whole, repeated or cut short
        while (random_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0)
                comp = ($urandom_range(0, 1) == 0) ? COMP_SPARE_6 : COMP_SPARE_7;
            else
                comp = COMP_BITS'($urandom_range(0, 5));
            sx = 9'($urandom_range(1, 4));
            sy = 9'($urandom_range(1, 4));
            sz = 9'($urandom_range(1, 6));
            box = sx * sy * sz;
            case ($urandom_range(0, 3))
                0:       n_items = $urandom_range(1, box);
                1:       n_items = 2 * box;
                default: n_items = box;
            endcase
            run_phase(comp, sx, sy, sz, n_items, 1'b0);
            random_items += n_items;
        end

        push <= 1'b0;
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d requests streamed over %0d box settings, including a stalled output",
                 requests_in, phases_run);
        $display("%0d results checked, %0d of them updated cells", cell_check.results_seen,
                 cell_check.updates_seen);
        if (cell_check.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
